### hdl/sorted_priority_queue_unit_defines.svh
// -----------------------------------------------------------------------------
// sorted priority queue assertion macros
// concurrent checks on clk, disabled while rst_n is low
// -----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");
// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT_IMP(lbl, ante, cons)
`define SPQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/spq_pkg.sv
// -----------------------------------------------------------------------------
// spq_pkg
// shared types and codes of the sorted priority queue
// -----------------------------------------------------------------------------
package spq_pkg;

    // fixed widths of the request and result fields
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;
    localparam int TOTAL_W = 5;

    // operation codes carried in s_tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_HEAD = 3'd0,
        MODE_PUSH_PRIO = 3'd1,
        MODE_POP_TAIL  = 3'd2,
        MODE_FIND      = 3'd3,
        MODE_REMOVE    = 3'd4
    } mode_t;

    // result status carried in m_tuser
    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    // per-cell update selection
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    // control sequencer
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

### hdl/spq_cell.sv
// -----------------------------------------------------------------------------
// spq_cell
// one slot of the queue chain: holds an entry, compares it, trades with neighbors
// -----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 32
)
(
    input  logic                 clk,
    input  cell_op_t             op,
    input  logic [ID_BITS-1:0]   req_id,
    input  logic [PRIO_BITS-1:0] req_prio,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic [ID_BITS-1:0]   left_id,
    input  logic [PRIO_BITS-1:0] left_prio,
    input  logic [ID_BITS-1:0]   right_id,
    input  logic [PRIO_BITS-1:0] right_prio,
    output logic [ID_BITS-1:0]   id,
    output logic [PRIO_BITS-1:0] prio,
    output logic                 gt,
    output logic                 eq
);

    logic [ID_BITS-1:0]   id_reg;
    logic [ID_BITS-1:0]   id_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;

    // entry update select
    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        unique case (op)
            CELL_HOLD:
            begin
                id_next   = id_reg;
                prio_next = prio_reg;
            end
            CELL_LOAD_NEW:
            begin
                id_next   = req_id;
                prio_next = new_prio;
            end
            CELL_FROM_LEFT:
            begin
                id_next   = left_id;
                prio_next = left_prio;
            end
            CELL_FROM_RIGHT:
            begin
                id_next   = right_id;
                prio_next = right_prio;
            end
            default:
            begin
                id_next   = id_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    // entry storage, payload only
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    // local compares against the request
    assign gt   = prio_reg > req_prio;
    assign eq   = id_reg == req_id;
    assign id   = id_reg;
    assign prio = prio_reg;

endmodule

### hdl/sorted_priority_queue_unit.sv
// -----------------------------------------------------------------------------
// sorted_priority_queue_unit
// ordered (id, priority) queue built as a chain of shifting slot cells
// -----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser holds the operation (push at head,
// push by priority, pop tail, find, remove), s_tdata the id and priority.
// Every request gives exactly one result beat on the m_ channel: m_tuser holds
// the status (ok, empty, full, not found), m_tdata the id, priority, position
// and entry count after the operation.
// A request is taken in the idle state and executed in the execute state,
// when all DEPTH cells compare against it at once and, for a push or a
// remove, shift toward tail or head together; the result is registered as
// it executes. No new request is taken until the current one has executed.
// The result sits in an output register, so the next request is accepted
// while it waits. If the receiver stalls, that next request waits in the
// execute step until the output register frees, and no further request is taken.
// Reset empties the queue at once (entry count zero), clears m_tvalid and
// returns the sequencer to idle; the slot contents are not cleared.
// -----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 32,
    localparam int S_DATA_W = ((ID_BITS + PRIO_BITS + 7) / 8) * 8,
    localparam int M_BITS   = ID_BITS + PRIO_BITS + POS_W + TOTAL_W,
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // item_id, priority_req
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode
    input  logic [MODE_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_id, out_priority, position, entry_total
    output logic [M_DATA_W-1:0] m_tdata,
    // status
    output logic [STAT_W-1:0]   m_tuser
);

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int COUNT_W  = $clog2(DEPTH + 1);
    localparam int LEVELS   = $clog2(DEPTH);

    // prefix or from head toward tail
    function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
        logic [DEPTH-1:0] p;
        p = v;
        for (int k = 0; k < LEVELS; k++)
        begin
            p = p | (p << (1 << k));
        end
        return p;
    endfunction

    state_t               state_reg;
    state_t               state_next;
    mode_t                mode_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [M_DATA_W-1:0]  m_tdata_next;
    logic [STAT_W-1:0]    m_tuser_reg;
    status_t              status_next;

    logic                 accept;
    logic                 adv;
    logic                 push_op;

    cell_op_t             cell_op   [DEPTH];
    logic [ID_BITS-1:0]   cell_id   [DEPTH];
    logic [PRIO_BITS-1:0] cell_prio [DEPTH];
    logic [DEPTH-1:0]     cell_gt;
    logic [DEPTH-1:0]     cell_eq;
    logic [DEPTH-1:0]     load_new;
    logic [PRIO_BITS-1:0] new_prio;

    logic [DEPTH-1:0]     occ;
    logic [DEPTH-1:0]     tail_hot;
    logic [DEPTH-1:0]     match;
    logic [DEPTH-1:0]     match_pre;
    logic [DEPTH-1:0]     first_hot;
    logic [DEPTH-1:0]     not_gt;
    logic [DEPTH-1:0]     stop_pre;
    logic [DEPTH-1:0]     ins_hot;
    logic [DEPTH-1:0]     sel_hot;
    logic                 full;
    logic                 empty;
    logic                 found;
    logic [ID_BITS-1:0]   sel_id;
    logic [PRIO_BITS-1:0] sel_prio;
    logic [IDX_W-1:0]     sel_idx;
    logic [ID_BITS-1:0]   res_id;
    logic [PRIO_BITS-1:0] res_prio;
    logic [POS_W+IDX_W-1:0]       pos_wide;
    logic [TOTAL_W+COUNT_W-1:0]   total_wide;

    // request handshake
    assign accept = s_tvalid && s_tready;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: if (adv)      state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        adv      = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EXEC: adv      = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_t'(s_tuser);
            id_reg   <= s_tdata[ID_BITS-1:0];
            prio_reg <= s_tdata[ID_BITS+PRIO_BITS-1:ID_BITS];
        end
    end

    // push request flag
    assign push_op = (mode_reg == MODE_PUSH_HEAD) || (mode_reg == MODE_PUSH_PRIO);

    // occupancy and match vectors across the chain
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ[i] = COUNT_W'(i) < count_reg;
        end
        full      = count_reg == COUNT_W'(DEPTH);
        empty     = count_reg == '0;
        tail_hot  = occ & ~(occ >> 1);
        match     = occ & cell_eq;
        match_pre = prefix_or(match);
        first_hot = match & ~(match_pre << 1);
        found     = |match;
        not_gt    = ~(occ & cell_gt);
        stop_pre  = prefix_or(not_gt);
        ins_hot   = not_gt & ~(stop_pre << 1);
    end

    // per-cell operation select
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_op[i] = CELL_HOLD;
        end
        new_prio = prio_reg;
        if (adv)
        begin
            case (mode_reg)
                MODE_PUSH_HEAD:
                begin
                    new_prio = '0;
                    if (!full)
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            cell_op[i] = (i == 0) ? CELL_LOAD_NEW : CELL_FROM_LEFT;
                        end
                    end
                end
                MODE_PUSH_PRIO:
                begin
                    if (!full)
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (ins_hot[i])
                                cell_op[i] = CELL_LOAD_NEW;
                            else if (stop_pre[i])
                                cell_op[i] = CELL_FROM_LEFT;
                        end
                    end
                end
                MODE_REMOVE:
                begin
                    if (found)
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (match_pre[i])
                                cell_op[i] = CELL_FROM_RIGHT;
                        end
                    end
                end
                default:
                begin
                    new_prio = prio_reg;
                end
            endcase
        end
    end

    // chain of slot cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [ID_BITS-1:0]   lid;
        logic [PRIO_BITS-1:0] lprio;
        logic [ID_BITS-1:0]   rid;
        logic [PRIO_BITS-1:0] rprio;

        if (g == 0)
        begin : g_head
            assign lid   = id_reg;
            assign lprio = new_prio;
        end
        else
        begin : g_mid_l
            assign lid   = cell_id[g-1];
            assign lprio = cell_prio[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign rid   = cell_id[g];
            assign rprio = cell_prio[g];
        end
        else
        begin : g_mid_r
            assign rid   = cell_id[g+1];
            assign rprio = cell_prio[g+1];
        end

        assign load_new[g] = cell_op[g] == CELL_LOAD_NEW;

        spq_cell #(
            .ID_BITS   (ID_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op[g]),
            .req_id     (id_reg),
            .req_prio   (prio_reg),
            .new_prio   (new_prio),
            .left_id    (lid),
            .left_prio  (lprio),
            .right_id   (rid),
            .right_prio (rprio),
            .id         (cell_id[g]),
            .prio       (cell_prio[g]),
            .gt         (cell_gt[g]),
            .eq         (cell_eq[g])
        );
    end

    // one-hot read of the selected slot
    always_comb
    begin
        sel_hot  = (mode_reg == MODE_POP_TAIL) ? tail_hot : first_hot;
        sel_id   = '0;
        sel_prio = '0;
        sel_idx  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_id   = sel_id   | (cell_id[i]   & {ID_BITS{sel_hot[i]}});
            sel_prio = sel_prio | (cell_prio[i] & {PRIO_BITS{sel_hot[i]}});
            sel_idx  = sel_idx  | (IDX_W'(i)    & {IDX_W{sel_hot[i]}});
        end
    end

    // result and count update
    always_comb
    begin
        status_next = STAT_OK;
        count_next  = count_reg;
        res_id      = '0;
        res_prio    = '0;
        pos_wide    = '0;
        case (mode_reg) inside
            MODE_PUSH_HEAD, MODE_PUSH_PRIO:
            begin
                if (full)
                    status_next = STAT_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            MODE_POP_TAIL:
            begin
                if (empty)
                    status_next = STAT_EMPTY;
                else
                begin
                    count_next = count_reg - 1'b1;
                    res_id     = sel_id;
                    res_prio   = sel_prio;
                end
            end
            MODE_FIND, MODE_REMOVE:
            begin
                if (!found)
                    status_next = STAT_MISSING;
                else
                begin
                    res_id   = sel_id;
                    res_prio = sel_prio;
                    pos_wide = {{POS_W{1'b0}}, sel_idx};
                    if (mode_reg == MODE_REMOVE)
                        count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
        total_wide   = {{TOTAL_W{1'b0}}, count_next};
        m_tdata_next = M_DATA_W'({total_wide[TOTAL_W-1:0], pos_wide[POS_W-1:0],
                                  res_prio, res_id});
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (adv)
            count_reg <= count_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_W'(DEPTH))
    `SPQ_ASSERT_IMP(a_one_insert, 1'b1, $onehot0(load_new))
    `SPQ_ASSERT_NXT(a_result_loaded, adv, m_tvalid_reg)
    `SPQ_ASSERT_NXT(a_count_idle, !adv, $stable(count_reg))
    `SPQ_ASSERT_NXT(a_full_flag, adv && full && push_op, m_tuser_reg == STAT_FULL)

endmodule

### tb/tb_sorted_priority_queue_unit.sv
// -----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit
// self-checking bench for the sorted (id, priority) queue
// -----------------------------------------------------------------------------
// Requests go in on the s_ stream and every accepted request is run through
// a behavioral copy of the queue kept in this bench. The copy yields the
// result beat that the m_ stream must return. A short directed table comes
// first: an empty queue, extreme ids and priorities, equal priorities, a full
// queue, and position 15. A long random run follows. It swings between
// filling and draining, mostly reusing held ids so finds and removes hit. Both
// streams stall in random bursts, except in random stretches and the last one.
// -----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 64;
    localparam int RANDOM_ITEMS  = 850;
    localparam int QUIET_ITEMS   = 120;
    localparam int PRESSURE_AT   = 400;
    localparam int MAX_REPORTS   = 10;

    // one result beat, as the queue should return it
    typedef struct packed {
        status_t              status;
        logic [15:0]          out_id;
        logic [31:0]          out_prio;
        logic [POS_W-1:0]     position;
        logic [TOTAL_W-1:0]   total;
    } queue_result_t;

    // one row of the directed table; reps > 1 steps id up and priority down
    typedef struct {
        mode_t          op;
        logic [15:0]    id;
        logic [31:0]    prio;
        int             reps;
        bit             typed;
        queue_result_t  want;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [MODE_W-1:0]      s_tuser = MODE_PUSH_HEAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    // behavioral copy of the queue contents
    logic [15:0]            held_id [QUEUE_DEPTH];
    logic [31:0]            held_prio [QUEUE_DEPTH];
    int                     held_count = 0;

    queue_result_t          pending_results [$];
    directed_row_t          plan [$];
    queue_result_t          got_beat;
    queue_result_t          want_beat;
    int                     mismatches = 0;
    int                     beats_seen = 0;
    int                     op_count [5];
    int                     status_count [4];
    bit                     idle_on = 1'b1;
    int                     rx_stall_left = 0;

    sorted_priority_queue_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // apply one operation to the queue copy and return its result
    function automatic queue_result_t apply_queue_op(mode_t op, logic [15:0] id,
                                                     logic [31:0] prio);
        queue_result_t r;
        int at;
        r = '0;
        r.status = STAT_OK;
        at = 0;
        case (op) inside
            MODE_PUSH_HEAD, MODE_PUSH_PRIO:
            begin
                if (held_count >= QUEUE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    // ordered push goes before the first priority not greater
                    if (op == MODE_PUSH_PRIO)
                        while (at < held_count && held_prio[at] > prio)
                            at++;
                    for (int i = held_count; i > at; i--)
                    begin
                        held_id[i]   = held_id[i-1];
                        held_prio[i] = held_prio[i-1];
                    end
                    held_id[at]   = id;
                    held_prio[at] = (op == MODE_PUSH_PRIO) ? prio : 32'd0;
                    held_count++;
                end
            end
            MODE_POP_TAIL:
            begin
                if (held_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    held_count--;
                    r.out_id   = held_id[held_count];
                    r.out_prio = held_prio[held_count];
                end
            end
            MODE_FIND, MODE_REMOVE:
            begin
                // first match from the head
                while (at < held_count && held_id[at] != id)
                    at++;
                if (at >= held_count)
                    r.status = STAT_MISSING;
                else
                begin
                    r.out_id   = held_id[at];
                    r.out_prio = held_prio[at];
                    r.position = at[POS_W-1:0];
                    if (op == MODE_REMOVE)
                    begin
                        for (int i = at; i + 1 < held_count; i++)
                        begin
                            held_id[i]   = held_id[i+1];
                            held_prio[i] = held_prio[i+1];
                        end
                        held_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.total = held_count[TOTAL_W-1:0];
        return r;
    endfunction

    // result with zero id, priority and position
    function automatic queue_result_t plain_result(status_t st, int total);
        queue_result_t r;
        r = '0;
        r.status = st;
        r.total  = total[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic add_row(mode_t op, logic [15:0] id, logic [31:0] prio, int reps,
                           bit typed, queue_result_t want);
        directed_row_t row;
        row.op    = op;
        row.id    = id;
        row.prio  = prio;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // drive one request beat and record its expected result on accept
    task automatic send_request(mode_t op, logic [15:0] id, logic [31:0] prio,
                                bit typed, queue_result_t want);
        queue_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {prio, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_queue_op(op, id, prio);
        pending_results.push_back(typed ? want : predicted);
        op_count[op]++;
        status_count[predicted.status]++;
    endtask

    // random sender gap
    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // receiver backpressure in bursts
    always @(posedge clk)
    begin
        if (idle_on && rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_stall_left = $urandom_range(1, 6) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_seen++;
            got_beat.status   = status_t'(m_tuser);
            got_beat.out_id   = m_tdata[15:0];
            got_beat.out_prio = m_tdata[47:16];
            got_beat.position = m_tdata[51:48];
            got_beat.total    = m_tdata[56:52];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected result beat %0d", beats_seen);
                    $display("  status=%0d id=%h prio=%h pos=%0d total=%0d",
                             got_beat.status, got_beat.out_id,
                             got_beat.out_prio, got_beat.position, got_beat.total);
                end
            end
            else
            begin
                want_beat = pending_results.pop_front();
                if (got_beat !== want_beat)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch on beat %0d", beats_seen);
                        $display("  expected status=%0d id=%h prio=%h pos=%0d total=%0d",
                                 want_beat.status, want_beat.out_id,
                                 want_beat.out_prio, want_beat.position, want_beat.total);
                        $display("  actual   status=%0d id=%h prio=%h pos=%0d total=%0d",
                                 got_beat.status, got_beat.out_id, got_beat.out_prio,
                                 got_beat.position, got_beat.total);
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int          bias;
        int          pick;
        mode_t       op;
        logic [15:0] id;
        logic [31:0] prio;

        foreach (op_count[i])
            op_count[i] = 0;
        foreach (status_count[i])
            status_count[i] = 0;

        // directed table: empty queue, extremes, equal priorities, full queue
        add_row(MODE_POP_TAIL,  16'h0000, 32'h0000_0000, 1, 1, plain_result(STAT_EMPTY, 0));
        add_row(MODE_FIND,      16'h1234, 32'h0000_0000, 1, 1, plain_result(STAT_MISSING, 0));
        add_row(MODE_REMOVE,    16'hFFFF, 32'hFFFF_FFFF, 1, 1, plain_result(STAT_MISSING, 0));
        add_row(MODE_PUSH_HEAD, 16'h0000, 32'hFFFF_FFFF, 1, 1, plain_result(STAT_OK, 1));
        add_row(MODE_PUSH_PRIO, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, plain_result(STAT_OK, 2));
        add_row(MODE_PUSH_PRIO, 16'h0001, 32'h0000_0000, 1, 0, '0);
        add_row(MODE_PUSH_PRIO, 16'hAAAA, 32'h8000_0000, 1, 0, '0);
        add_row(MODE_PUSH_PRIO, 16'h5555, 32'h8000_0000, 1, 0, '0);
        add_row(MODE_FIND,      16'hFFFF, 32'h0000_0000, 1, 0, '0);
        add_row(MODE_FIND,      16'h0000, 32'hFFFF_FFFF, 1, 0, '0);
        add_row(MODE_REMOVE,    16'hAAAA, 32'h0000_0000, 1, 0, '0);
        add_row(MODE_POP_TAIL,  16'h0000, 32'h0000_0000, 1, 0, '0);
        add_row(MODE_PUSH_PRIO, 16'h0100, 32'h7000_0000, 13, 0, '0);
        add_row(MODE_PUSH_PRIO, 16'h7777, 32'hFFFF_FFFF, 1, 1, plain_result(STAT_FULL, 16));
        add_row(MODE_PUSH_HEAD, 16'h8888, 32'h0000_0000, 1, 1, plain_result(STAT_FULL, 16));
        add_row(MODE_FIND,      16'h0001, 32'h0000_0000, 1, 0, '0);
        add_row(MODE_REMOVE,    16'h0001, 32'h0000_0000, 1, 0, '0);

        // reset
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
            for (int k = 0; k < plan[r].reps; k++)
            begin
                maybe_gap();
                send_request(plan[r].op, plan[r].id + k[15:0], plan[r].prio - k,
                             plan[r].typed, plan[r].want);
            end

        // random traffic, swinging between fill and drain
        bias = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            if (n % 40 == 0)
                bias = $urandom_range(0, 2);

            // hold off until every result is back
            if (n == PRESSURE_AT)
            begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end

            // operation mix by bias: 0 drain, 1 balanced, 2 fill
            pick = $urandom_range(0, 99);
            case (bias)
                0:       op = (pick < 8)  ? MODE_PUSH_HEAD : (pick < 20) ? MODE_PUSH_PRIO :
                              (pick < 60) ? MODE_POP_TAIL  : (pick < 80) ? MODE_FIND :
                                            MODE_REMOVE;
                2:       op = (pick < 15) ? MODE_PUSH_HEAD : (pick < 60) ? MODE_PUSH_PRIO :
                              (pick < 70) ? MODE_POP_TAIL  : (pick < 90) ? MODE_FIND :
                                            MODE_REMOVE;
                default: op = (pick < 10) ? MODE_PUSH_HEAD : (pick < 35) ? MODE_PUSH_PRIO :
                              (pick < 55) ? MODE_POP_TAIL  : (pick < 80) ? MODE_FIND :
                                            MODE_REMOVE;
            endcase

            // ids: mostly held ones or a small pool, so lookups hit and repeat
            pick = $urandom_range(0, 99);
            if (held_count > 0 && pick < 55)
                id = held_id[$urandom_range(0, held_count - 1)];
            else if (pick < 75)
                id = 16'($urandom_range(0, 7));
            else if (pick < 92)
                id = 16'($urandom);
            else
                id = (pick[0]) ? 16'hFFFF : 16'h0000;

            // priorities: extremes, small ties, or anything
            pick = $urandom_range(0, 9);
            if (pick < 3)
                case ($urandom_range(0, 3))
                    0:       prio = 32'h0000_0000;
                    1:       prio = 32'h0000_0001;
                    2:       prio = 32'h8000_0000;
                    default: prio = 32'hFFFF_FFFF;
                endcase
            else if (pick < 6)
                prio = $urandom_range(0, 7);
            else
                prio = $urandom;

            maybe_gap();
            send_request(op, id, prio, 1'b0, '0);
        end

        // drain and settle
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        $display("ran %0d beats: %0d head, %0d ordered, %0d pop, %0d find, %0d remove",
                 beats_seen, op_count[MODE_PUSH_HEAD], op_count[MODE_PUSH_PRIO],
                 op_count[MODE_POP_TAIL], op_count[MODE_FIND], op_count[MODE_REMOVE]);
        $display("outcomes: %0d ok, %0d empty, %0d full, %0d not found, %0d mismatches",
                 status_count[STAT_OK], status_count[STAT_EMPTY], status_count[STAT_FULL],
                 status_count[STAT_MISSING], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
tb/tb_sorted_priority_queue_unit.sv
